/* hw/rtl/tqs_pkg.sv */
// Shared types, codes and constants of the timer queue scheduler.
package tqs_pkg;

  localparam int TimerSlots = 16;
  localparam int MaxFires   = 16;

  localparam logic [1:0] OP_SCHEDULE   = 2'd0;
  localparam logic [1:0] OP_RESCHEDULE = 2'd1;
  localparam logic [1:0] OP_CANCEL     = 2'd2;
  localparam logic [1:0] OP_TICK       = 2'd3;

  localparam logic [2:0] KIND_SCHEDULED = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_DONE      = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
  localparam logic [2:0] KIND_FIRED     = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] deadline;
    logic [31:0] interval;
    logic [31:0] timer_id;
  } cmd_t;

endpackage

/* hw/rtl/tqs_front.sv */
// Front end: takes input words, decodes them into commands and queues them.
module tqs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [111:0]       s_axis_tdata,  // when[47:0], interval[79:48], timer_id[111:80]
  input  logic [1:0]         s_axis_tuser,  // op
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output tqs_pkg::cmd_t      cmd
);
  import tqs_pkg::*;

  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;
  cmd_t       dec;

  always_comb begin
    dec.op       = s_axis_tuser;
    dec.deadline = s_axis_tdata[47:0];
    dec.interval = s_axis_tdata[79:48];
    dec.timer_id = s_axis_tdata[111:80];
  end

  assign s_axis_tready = (cnt != 2'd2);
  assign cmd_valid     = (cnt != 2'd0);
  assign cmd           = q[rp];
  assign push          = s_axis_tvalid && s_axis_tready;
  assign pop           = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/tqs_back.sv */
// Back end: scans the timer table one slot a cycle and carries out commands.
module tqs_back #(
  parameter int TIMER_SLOTS = tqs_pkg::TimerSlots
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  tqs_pkg::cmd_t      cmd_in,
  input  logic               cfg_valid,
  input  logic               cfg_data,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,  // result_id
  output logic [2:0]         m_axis_tuser,  // kind
  output logic               m_axis_tlast
);
  import tqs_pkg::*;

  localparam int IW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(MaxFires + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_ACT   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [31:0] mem_id  [TIMER_SLOTS];
  logic [47:0] mem_dl  [TIMER_SLOTS];
  logic [31:0] mem_per [TIMER_SLOTS];

  logic [2:0]  state;
  cmd_t        cmd;
  logic [IW-1:0] idx, p_idx, sel;
  logic        p_vld;
  logic [31:0] rd_id, rd_per;
  logic [47:0] rd_dl;
  logic        found;
  logic [47:0] best_dl;
  logic [31:0] best_id, best_per;
  logic [TIMER_SLOTS-1:0] slot_valid, fired;
  logic [47:0] time_now;
  logic [31:0] id_counter;
  logic        running;
  logic        pend_valid;
  logic [31:0] pend_id;
  logic [CW-1:0] fire_cnt;

  logic        out_free;
  logic        emit, e_last;
  logic [2:0]  e_kind;
  logic [31:0] e_id;
  logic        id_we, dl_we, per_we;
  logic [47:0] wd_dl;
  logic        act_go;
  logic        due, better, hit;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cmd_ready = (state == ST_IDLE);

  always_comb begin
    due    = slot_valid[p_idx] && !fired[p_idx] && (rd_dl <= time_now);
    better = !found || (rd_dl < best_dl) || ((rd_dl == best_dl) && (rd_id < best_id));
    hit    = 1'b0;
    if (p_vld && !found) begin
      unique case (cmd.op)
        OP_SCHEDULE:   hit = !slot_valid[p_idx];
        OP_RESCHEDULE,
        OP_CANCEL:     hit = slot_valid[p_idx] && (rd_id == cmd.timer_id);
        default:       hit = 1'b0;
      endcase
    end
    if (p_vld && cmd.op == OP_TICK) begin
      hit = due && better;
    end
  end

  always_comb begin
    emit   = 1'b0;
    e_last = 1'b1;
    e_kind = KIND_SCHEDULED;
    e_id   = 32'd0;
    id_we  = 1'b0;
    dl_we  = 1'b0;
    per_we = 1'b0;
    wd_dl  = cmd.deadline;
    act_go = 1'b0;
    if (state == ST_ACT) begin
      unique case (cmd.op)
        OP_SCHEDULE: begin
          act_go = out_free;
          emit   = out_free;
          e_kind = found ? KIND_SCHEDULED : KIND_FULL;
          e_id   = found ? id_counter + 32'd1 : 32'd0;
          id_we  = out_free && found;
          dl_we  = out_free && found;
          per_we = out_free && found;
        end
        OP_RESCHEDULE, OP_CANCEL: begin
          act_go = out_free;
          emit   = out_free;
          e_kind = found ? KIND_DONE : KIND_NOT_FOUND;
          e_id   = cmd.timer_id;
          dl_we  = out_free && found && (cmd.op == OP_RESCHEDULE);
        end
        default: begin
          act_go = !(found && pend_valid) || out_free;
          if (found && pend_valid) begin
            emit   = out_free;
            e_kind = KIND_FIRED;
            e_id   = pend_id;
            e_last = 1'b0;
          end
          wd_dl = time_now + {16'd0, best_per};
          dl_we = act_go && found && (best_per != 32'd0);
        end
      endcase
    end else if (state == ST_FLUSH) begin
      emit   = out_free;
      e_kind = KIND_FIRED;
      e_id   = pend_id;
    end
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      mem_id[sel] <= id_counter + 32'd1;
    end
    if (dl_we) begin
      mem_dl[sel] <= wd_dl;
    end
    if (per_we) begin
      mem_per[sel] <= cmd.interval;
    end
    rd_id  <= mem_id[idx];
    rd_dl  <= mem_dl[idx];
    rd_per <= mem_per[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      slot_valid    <= '0;
      fired         <= '0;
      time_now      <= 48'd0;
      id_counter    <= 32'd0;
      running       <= 1'b1;
      p_vld         <= 1'b0;
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
      found         <= 1'b0;
      fire_cnt      <= '0;
    end else begin
      if (cfg_valid) begin
        running <= cfg_data;
      end
      if (emit) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= e_id;
        m_axis_tuser  <= e_kind;
        m_axis_tlast  <= e_last;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      p_vld <= 1'b0;
      if (hit) begin
        found    <= 1'b1;
        sel      <= p_idx;
        best_dl  <= rd_dl;
        best_id  <= rd_id;
        best_per <= rd_per;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cmd   <= cmd_in;
            idx   <= '0;
            found <= 1'b0;
            state <= ST_SCAN;
            if (cmd_in.op == OP_TICK) begin
              time_now   <= time_now + 48'd1;
              fired      <= '0;
              fire_cnt   <= '0;
              pend_valid <= 1'b0;
              if (!running) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_SCAN: begin
          p_vld <= 1'b1;
          p_idx <= idx;
          if (idx == IW'(TIMER_SLOTS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_ACT;
        end
        ST_ACT: begin
          if (act_go) begin
            unique case (cmd.op)
              OP_SCHEDULE: begin
                if (found) begin
                  slot_valid[sel] <= 1'b1;
                  id_counter      <= id_counter + 32'd1;
                end
                state <= ST_IDLE;
              end
              OP_RESCHEDULE: begin
                state <= ST_IDLE;
              end
              OP_CANCEL: begin
                if (found) begin
                  slot_valid[sel] <= 1'b0;
                end
                state <= ST_IDLE;
              end
              default: begin
                if (found) begin
                  fired[sel] <= 1'b1;
                  if (best_per == 32'd0) begin
                    slot_valid[sel] <= 1'b0;
                  end
                  pend_valid <= 1'b1;
                  pend_id    <= best_id;
                  fire_cnt   <= fire_cnt + 1'b1;
                  idx        <= '0;
                  found      <= 1'b0;
                  if (fire_cnt == CW'(MaxFires - 1)) begin
                    state <= ST_FLUSH;
                  end else begin
                    state <= ST_SCAN;
                  end
                end else begin
                  state <= pend_valid ? ST_FLUSH : ST_IDLE;
                end
              end
            endcase
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/timer_queue_scheduler_core.sv */
// Top level of the timer queue scheduler: front decoder, command queue, table engine.
//
// Input words arrive on s_axis: tuser carries the op (schedule, reschedule,
// cancel, tick), tdata the deadline, interval and timer id. Results leave on
// m_axis: tuser is the kind, tdata the id, tlast marks the last word that an
// input word causes. A tick that fires nothing gives no word.
// The running register is written on the cfg channel, which is always ready.
// A two-entry queue sits between the decoder and the table engine, so up to two input
// words are taken while the engine works or while the output stalls.
// Each command scans the table one slot a cycle through the slot memories:
// schedule, reschedule and cancel run one scan, a drain state and an act
// state. A tick advances time, then runs a scan per fired timer plus one
// final scan (none after the sixteenth firing), and a flush state for the
// last firing; a tick while stopped skips the scan, but time still advances.
// Up to 16 firings per tick. A stalled output holds the engine only when it has a word to emit.
// Reset (rst, synchronous) empties the table, clears time and the id counter
// and sets running to 1.
module timer_queue_scheduler_core #(
  parameter int TIMER_SLOTS = tqs_pkg::TimerSlots
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,  // when[47:0], interval[79:48], timer_id[111:80]
  input  logic [1:0]   s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // result_id
  output logic [2:0]   m_axis_tuser,  // kind
  output logic         m_axis_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data
);
  import tqs_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  assign cfg_ready = 1'b1;

  tqs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  tqs_back #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd_in        (cmd),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
